/* hdl/pwg_pkg.sv */
// ----------------------------------------------------------------------------
// pwg_pkg
// Shared types, constants and the quarter-wave sine table for the periodic
// waveform sample generator.
// ----------------------------------------------------------------------------
package pwg_pkg;

	localparam int IDX_W     = 12;
	localparam int PER_W     = 13;
	localparam int AMP_W     = 9;
	localparam int KIND_W    = 3;
	localparam int SMP_W     = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 13;

	localparam logic [PER_W-1:0] MAX_POINTS = 13'd4096;
	localparam int QTR_N     = 1024;
	localparam int QTR_W     = $clog2(QTR_N);
	localparam int TAB_AW    = QTR_W + 1;
	localparam int TAB_W     = 15;
	localparam int NUM_W     = 24;
	localparam int QUO_W     = 12;
	localparam int DIV_STG   = 6;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAVE_KIND = 2'd0,
		REG_PERIOD    = 2'd1,
		REG_FULL      = 2'd2,
		REG_AMP       = 2'd3
	} pwg_reg_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_SINE     = 3'd0,
		KIND_SQUARE   = 3'd1,
		KIND_TRIANGLE = 3'd2,
		KIND_RISE     = 3'd3,
		KIND_FALL     = 3'd4
	} pwg_kind_t;

	// how the quotient is folded into the final sample
	typedef enum logic [2:0] {
		M_SINE,
		M_SQ_HI,
		M_SQ_LO,
		M_ADD,
		M_SUB,
		M_ZERO
	} pwg_mode_t;

	typedef logic [TAB_W-1:0] sine_tab_t [QTR_N+1];

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t t;
		longint unsigned x, x2, term, res;
		longint sum;
		for (int k = 0; k <= QTR_N; k++) begin
			x = (longint'(k) * HALF_PI_Q30) / QTR_N;
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			// taylor terms through x^17, divisors (2n)(2n+1)
			term = ((term * x2) >> 30) / 6;
			sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 20;
			sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 42;
			sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 72;
			sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 110;
			sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 156;
			sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 210;
			sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 272;
			sum = sum + longint'(term);
			if (sum < 0)
				sum = 0;
			if (sum > (longint'(1) << 30))
				sum = longint'(1) << 30;
			res = ((longint'(sum) * 32767) + (longint'(1) << 29)) >> 30;
			t[k] = res[TAB_W-1:0];
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

	function automatic logic [SMP_W-1:0] sat8(input logic signed [13:0] v);
		if (v < 0)
			return '0;
		else if (v > 14'sd255)
			return '1;
		else
			return v[SMP_W-1:0];
	endfunction

endpackage

/* hdl/pwg_if.sv */
// ----------------------------------------------------------------------------
// pwg_in_if / pwg_out_if
// Valid/ready channels carrying sample indices in and samples out.
// ----------------------------------------------------------------------------
interface pwg_in_if import pwg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] sample_index;

	modport source (output valid, output sample_index, input ready);
	modport sink (input valid, input sample_index, output ready);
endinterface

interface pwg_out_if import pwg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SMP_W-1:0] sample_value;
	logic             index_out_of_range;

	modport source (output valid, output sample_value, output index_out_of_range, input ready);
	modport sink (input valid, input sample_value, input index_out_of_range, output ready);
endinterface

/* hdl/periodic_waveform_sample_generator.sv */
// ----------------------------------------------------------------------------
// periodic_waveform_sample_generator
// Sine, square, triangle and sawtooth samples from an index within a period.
// ----------------------------------------------------------------------------
// One word in, one word out, and a new index can be taken every clock while
// intake is not stalled. The pipeline is: input register, the
// index-times-amplitude multiply, six stages of a restoring divider by the
// period (two quotient bits per stage), the quarter-wave sine table read,
// the amplitude scaling multiply, and the output register. Each stage holds
// its word while the next one is full and does not move on, so back-pressure
// on the output only stops intake once every stage is occupied.
// Configuration must be written while the pipeline is empty.
module periodic_waveform_sample_generator import pwg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	pwg_in_if.sink               smp_in,
	pwg_out_if.source            smp_out
);

	localparam int NST = 11;
	localparam int OST = NST - 1;

	logic [KIND_W-1:0] wave_kind_q;
	logic [PER_W-1:0]  period_q;
	logic [AMP_W-1:0]  full_q;
	logic [AMP_W-1:0]  amp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_kind_q <= KIND_SINE;
			period_q    <= 13'd256;
			full_q      <= 9'd256;
			amp_q       <= 9'd256;
		end else if (cfg_wen) begin
			case (pwg_reg_t'(cfg_addr))
				REG_WAVE_KIND: wave_kind_q <= cfg_wdata[KIND_W-1:0];
				REG_PERIOD:    period_q    <= cfg_wdata;
				REG_FULL:      full_q      <= cfg_wdata[AMP_W-1:0];
				REG_AMP:       amp_q       <= cfg_wdata[AMP_W-1:0];
				default:       ;
			endcase
		end
	end

	// valid chain, each stage moves when it is empty or its successor moves
	logic [NST-1:0] vld_s;
	logic [NST-1:0] adv;

	always_comb begin
		adv[OST] = !vld_s[OST] || smp_out.ready;
		for (int k = OST - 1; k >= 0; k--)
			adv[k] = !vld_s[k] || adv[k+1];
	end

	assign smp_in.ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0])
				vld_s[0] <= smp_in.valid;
			for (int k = 1; k < NST; k++)
				if (adv[k])
					vld_s[k] <= vld_s[k-1];
		end
	end

	// period, clamped
	logic [PER_W-1:0] per_c;
	assign per_c = (period_q > MAX_POINTS) ? MAX_POINTS : period_q;

	// stage 1: index register
	logic [IDX_W-1:0] idx_s1;

	always_ff @(posedge clk)
		if (adv[0])
			idx_s1 <= smp_in.sample_index;

	// side band carried along the pipe
	pwg_mode_t mode_s [NST];
	logic      oor_s  [NST];

	// stage 1 logic: pick mode and build the numerator
	logic [PER_W-1:0]  half_p;
	logic              lo_half;
	logic              oor_c;
	logic [IDX_W-1:0]  mop;
	logic [20:0]       mprod;
	logic [NUM_W-1:0]  num_c;
	pwg_mode_t         mode_c;

	always_comb begin
		half_p  = per_c >> 1;
		oor_c   = {1'b0, idx_s1} >= per_c;
		lo_half = {1'b0, idx_s1} < half_p;
		mop     = idx_s1;
		if (wave_kind_q == KIND_TRIANGLE && !lo_half)
			mop = idx_s1 - half_p[IDX_W-1:0];
		mprod  = 21'(mop) * 21'(amp_q);
		num_c  = '0;
		mode_c = M_ZERO;
		case (pwg_kind_t'(wave_kind_q))
			KIND_SINE: begin
				mode_c = M_SINE;
				num_c  = {idx_s1, {QUO_W{1'b0}}};
			end
			KIND_SQUARE: begin
				mode_c = lo_half ? M_SQ_HI : M_SQ_LO;
			end
			KIND_TRIANGLE: begin
				if (lo_half) begin
					mode_c = M_ADD;
					num_c  = NUM_W'({mprod, 1'b0});
				end else begin
					mode_c = M_SUB;
					num_c  = NUM_W'({mprod, 1'b0}) + NUM_W'(per_c) - 24'd1;
				end
			end
			KIND_RISE: begin
				mode_c = M_ADD;
				num_c  = NUM_W'(mprod);
			end
			KIND_FALL: begin
				mode_c = M_SUB;
				num_c  = NUM_W'(mprod) + NUM_W'(per_c) - 24'd1;
			end
			default: mode_c = M_ZERO;
		endcase
	end

	logic [NUM_W-1:0] num_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			num_s2    <= num_c;
			mode_s[1] <= mode_c;
			oor_s[1]  <= oor_c;
		end
		if (adv[0]) begin
			mode_s[0] <= M_ZERO;
			oor_s[0]  <= 1'b0;
		end
		for (int k = 2; k < NST; k++)
			if (adv[k]) begin
				mode_s[k] <= mode_s[k-1];
				oor_s[k]  <= oor_s[k-1];
			end
	end

	// divider stages 3..8: remainder and a word that shifts numerator out, quotient in
	logic [PER_W-1:0] dr_s [2:7];
	logic [QUO_W-1:0] dn_s [2:7];

	function automatic logic [PER_W+QUO_W-1:0] div_step2(
		input logic [PER_W-1:0] rem,
		input logic [QUO_W-1:0] nq,
		input logic [PER_W-1:0] dvs
	);
		logic [PER_W:0]   r;
		logic [PER_W-1:0] rr;
		logic [QUO_W-1:0] q;
		rr = rem;
		q  = nq;
		for (int b = 0; b < 2; b++) begin
			r = {rr, q[QUO_W-1]};
			q = {q[QUO_W-2:0], 1'b0};
			if (r >= {1'b0, dvs}) begin
				r = r - {1'b0, dvs};
				q[0] = 1'b1;
			end
			rr = r[PER_W-1:0];
		end
		return {rr, q};
	endfunction

	logic [PER_W+QUO_W-1:0] dstep [2:7];

	assign dstep[2] = div_step2({1'b0, num_s2[NUM_W-1:QUO_W]}, num_s2[QUO_W-1:0], per_c);

	for (genvar g = 3; g <= 7; g++) begin : g_div
		assign dstep[g] = div_step2(dr_s[g-1], dn_s[g-1], per_c);
	end

	always_ff @(posedge clk)
		for (int k = 2; k <= 7; k++)
			if (adv[k]) begin
				dr_s[k] <= dstep[k][PER_W+QUO_W-1:QUO_W];
				dn_s[k] <= dstep[k][QUO_W-1:0];
			end

	// stage 9: quarter-wave table read
	logic [QUO_W-1:0]  phase;
	logic [TAB_AW-1:0] tab_addr;
	logic [TAB_W-1:0]  tab_s9;
	logic              neg_s9;
	logic [QUO_W-1:0]  quo_s9;

	assign phase    = dn_s[7];
	assign tab_addr = phase[QTR_W] ? (TAB_AW'(QTR_N) - TAB_AW'(phase[QTR_W-1:0]))
	                               : TAB_AW'(phase[QTR_W-1:0]);

	always_ff @(posedge clk)
		if (adv[8]) begin
			tab_s9 <= SINE_TAB[tab_addr];
			neg_s9 <= phase[QTR_W+1];
			quo_s9 <= phase;
		end

	// stage 10: scale by half amplitude, magnitude truncated
	logic [SMP_W+TAB_W-1:0] sprod;
	logic [SMP_W-1:0]       mag_s10;
	logic                   neg_s10;
	logic [QUO_W-1:0]       quo_s10;

	assign sprod = (SMP_W+TAB_W)'(amp_q[AMP_W-1:1]) * (SMP_W+TAB_W)'(tab_s9);

	always_ff @(posedge clk)
		if (adv[9]) begin
			mag_s10 <= sprod[SMP_W+TAB_W-1:TAB_W];
			neg_s10 <= neg_s9;
			quo_s10 <= quo_s9;
		end

	// output stage: offset, fold and saturate
	logic signed [13:0] diff;
	logic signed [13:0] off;
	logic signed [13:0] amp_x;
	logic signed [13:0] quo_x;
	logic signed [13:0] sine_x;
	logic [SMP_W-1:0]   smp_c;

	always_comb begin
		diff   = 14'(signed'({1'b0, full_q})) - 14'(signed'({1'b0, amp_q}));
		// halve toward zero
		off    = (diff + $signed(14'(diff < 0))) >>> 1;
		amp_x  = 14'(signed'({1'b0, amp_q}));
		quo_x  = 14'(signed'({1'b0, quo_s10}));
		sine_x = 14'(signed'({1'b0, full_q[AMP_W-1:1]}));
		if (neg_s10)
			sine_x = sine_x - 14'(signed'({1'b0, mag_s10}));
		else
			sine_x = sine_x + 14'(signed'({1'b0, mag_s10}));
		case (mode_s[9])
			M_SINE:  smp_c = sat8(sine_x);
			M_SQ_HI: smp_c = sat8(off + amp_x - 14'sd1);
			M_SQ_LO: smp_c = sat8(off);
			M_ADD:   smp_c = sat8(off + quo_x);
			M_SUB:   smp_c = sat8(off + amp_x - 14'sd1 - quo_x);
			default: smp_c = '0;
		endcase
		if (oor_s[9])
			smp_c = '0;
	end

	logic [SMP_W-1:0] smp_q;

	always_ff @(posedge clk)
		if (adv[OST])
			smp_q <= smp_c;

	assign smp_out.valid              = vld_s[OST];
	assign smp_out.sample_value       = smp_q;
	assign smp_out.index_out_of_range = oor_s[OST];

`ifndef SYNTHESIS
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		smp_out.valid && smp_out.index_out_of_range |-> smp_out.sample_value == '0)
		else $error("out-of-range word with non-zero sample");

	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!smp_in.ready |-> &vld_s)
		else $error("intake stalled with a bubble in the pipe");

	a_entry_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_s[0]) |-> $past(smp_in.valid && smp_in.ready))
		else $error("first stage filled without an accepted word");

	a_bad_kind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		smp_out.valid && mode_s[OST] == M_ZERO |-> smp_out.sample_value == '0)
		else $error("undefined wave kind gave a non-zero sample");
`endif

endmodule
